/* design/rta_pkg.sv */
// Shared types, operation and status codes, and datapath command codes
// for the region table allocator. No dependencies.
`timescale 1ns / 1ps
package rta_pkg;

  localparam int REGION_SLOTS = 128;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_RESERVE = 2'd1;
  localparam logic [1:0] OP_ALLOC   = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NOP      = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 5'd1;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 5'd2;
  localparam logic [CMD_W-1:0] CMD_I_RD     = 5'd3;
  localparam logic [CMD_W-1:0] CMD_I_EV     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_M_RD     = 5'd5;
  localparam logic [CMD_W-1:0] CMD_M_EV     = 5'd6;
  localparam logic [CMD_W-1:0] CMD_M_END    = 5'd7;
  localparam logic [CMD_W-1:0] CMD_SU_RD    = 5'd8;
  localparam logic [CMD_W-1:0] CMD_SU_WR    = 5'd9;
  localparam logic [CMD_W-1:0] CMD_SD_RD    = 5'd10;
  localparam logic [CMD_W-1:0] CMD_SD_WR    = 5'd11;
  localparam logic [CMD_W-1:0] CMD_G_URD    = 5'd12;
  localparam logic [CMD_W-1:0] CMD_G_UEV    = 5'd13;
  localparam logic [CMD_W-1:0] CMD_G_TOP    = 5'd14;
  localparam logic [CMD_W-1:0] CMD_G_FIT    = 5'd15;
  localparam logic [CMD_W-1:0] CMD_G_RRD    = 5'd16;
  localparam logic [CMD_W-1:0] CMD_G_REV    = 5'd17;
  localparam logic [CMD_W-1:0] CMD_DONE     = 5'd18;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] base_addr;
    logic [63:0] length;
    logic [63:0] limit_addr;
    logic [5:0]  align_log2;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] result_addr;
  } rsp_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] stop;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic i_lt_n;
    logic ins_below;
    logic k_lt_n;
    logic merge_hit;
    logic k_eq_i;
    logic full;
    logic m_gt_i;
    logic m_lt_n;
    logic ins_zero;
    logic gap_bad;
    logic ui_lt_un;
    logic u_before;
    logic u_after;
    logic top_stop;
    logic fit_fail;
    logic j_lt_rn;
    logic r_below;
    logic r_clear;
  } flags_t;

endpackage

/* design/region_table_allocator_top.sv */
// Region table allocator: one request in, one response out, one request at a time.
// Add or reserve: walks, merges and shifts table entries one read at a time;
// the response can then be held by output stalls.
// Allocate or query: passes usable and reserved entries and tries placements,
// then allocate inserts as above; each table has a single read port.
// Synchronous reset empties both tables (counts to zero); no clearing pass.
`timescale 1ns / 1ps
module region_table_allocator_top #(
  parameter int SLOTS = rta_pkg::REGION_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rta_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rta_pkg::rsp_t rsp
);

  rta_pkg::cmd_t   cmd;
  rta_pkg::flags_t flags;

  rta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  rta_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .req   (req),
    .flags (flags),
    .rsp   (rsp)
  );

endmodule

/* design/rta_datapath.sv */
// Datapath: request registers, the two region table memories, scan and
// shift pointers, gap search registers and the response register. Uses rta_pkg.
`timescale 1ns / 1ps
module rta_datapath #(
  parameter int SLOTS = rta_pkg::REGION_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  rta_pkg::cmd_t cmd,
  input  rta_pkg::req_t req,
  output rta_pkg::flags_t flags,
  output rta_pkg::rsp_t rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  rta_pkg::entry_t umem [SLOTS];
  rta_pkg::entry_t rmem [SLOTS];
  rta_pkg::entry_t u_rd, r_rd, rd;

  rta_pkg::req_t cur;
  logic tsel;
  logic [63:0] a, e, ms, me;
  logic [63:0] from, to, mask, size, lo_hi_unused;
  logic [63:0] hi, addr, aligned, where;
  logic [CW-1:0] i, k, m, d, ui, j, cnt_u, cnt_r, n;
  logic [1:0] status;

  logic [63:0] len_c;
  logic clip;
  logic wen;
  logic [CW-1:0] wptr, rptr;
  rta_pkg::entry_t wdata;
  logic [63:0] lo;

  assign lo_hi_unused = 64'd0;
  assign rd = tsel ? r_rd : u_rd;
  assign n = tsel ? cnt_r : cnt_u;
  assign clip = cur.length > ~cur.base_addr;
  assign len_c = clip ? ~cur.base_addr : cur.length;
  assign lo = (u_rd.start > from) ? u_rd.start : from;

  always_comb begin
    flags.op        = cur.op;
    flags.i_lt_n    = i < n;
    flags.ins_below = rd.stop < a;
    flags.k_lt_n    = k < n;
    flags.merge_hit = rd.start <= me;
    flags.k_eq_i    = k == i;
    flags.full      = n >= CW'(SLOTS);
    flags.m_gt_i    = m > i;
    flags.m_lt_n    = m < n;
    flags.ins_zero  = len_c == 64'd0;
    if (cur.op == rta_pkg::OP_QUERY) begin
      flags.gap_bad = (cur.length == 64'd0) || clip;
    end else begin
      flags.gap_bad = (cur.length == 64'd0) || (cur.limit_addr <= cur.base_addr);
    end
    flags.ui_lt_un  = ui < cnt_u;
    flags.u_before  = u_rd.stop <= from;
    flags.u_after   = u_rd.start >= to;
    flags.top_stop  = (addr >= hi) || (addr > ~mask);
    flags.fit_fail  = (aligned > hi) || ((hi - aligned) < size);
    flags.j_lt_rn   = j < cnt_r;
    flags.r_below   = r_rd.stop <= addr;
    flags.r_clear   = r_rd.start >= (addr + size);
  end

  always_comb begin
    wen = 1'b0;
    wptr = i;
    wdata = '{start: ms, stop: me};
    rptr = i;
    case (cmd.code)
      rta_pkg::CMD_I_RD: rptr = i;
      rta_pkg::CMD_M_RD: rptr = k;
      rta_pkg::CMD_SD_RD: rptr = m;
      rta_pkg::CMD_G_URD: rptr = ui;
      rta_pkg::CMD_G_RRD: rptr = j;
      rta_pkg::CMD_M_END: begin
        wen = !flags.k_eq_i;
      end
      rta_pkg::CMD_SU_RD: begin
        rptr = m - CW'(1);
        wen = !flags.m_gt_i;
        wdata = '{start: a, stop: e};
      end
      rta_pkg::CMD_SU_WR: begin
        wen = 1'b1;
        wptr = m;
        wdata = rd;
      end
      rta_pkg::CMD_SD_WR: begin
        wen = 1'b1;
        wptr = d;
        wdata = rd;
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen && !tsel) begin
      umem[wptr[IW-1:0]] <= wdata;
    end
    if (wen && tsel) begin
      rmem[wptr[IW-1:0]] <= wdata;
    end
    u_rd <= umem[rptr[IW-1:0]];
    r_rd <= rmem[rptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_u <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.code == rta_pkg::CMD_SU_RD && !flags.m_gt_i) begin
        if (tsel) cnt_r <= cnt_r + CW'(1);
        else cnt_u <= cnt_u + CW'(1);
      end
      if (cmd.code == rta_pkg::CMD_SD_RD && !flags.m_lt_n) begin
        if (tsel) cnt_r <= d;
        else cnt_u <= d;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.code)
      rta_pkg::CMD_LOAD: begin
        cur <= req;
      end
      rta_pkg::CMD_DISPATCH: begin
        tsel <= cur.op[0];
        a <= cur.base_addr;
        e <= cur.base_addr + len_c;
        i <= '0;
        ui <= '0;
        j <= '0;
        from <= cur.base_addr;
        size <= cur.length;
        where <= 64'd0;
        if (cur.op == rta_pkg::OP_QUERY) begin
          to <= cur.base_addr + cur.length;
          mask <= 64'd0;
        end else begin
          to <= cur.limit_addr;
          mask <= (64'd1 << cur.align_log2) - 64'd1;
        end
        if (cur.op[1] && flags.gap_bad) status <= rta_pkg::ST_NOFIT;
        else status <= rta_pkg::ST_OK;
      end
      rta_pkg::CMD_I_RD: begin
        k <= i;
        ms <= a;
        me <= e;
      end
      rta_pkg::CMD_I_EV: begin
        if (flags.ins_below) i <= i + CW'(1);
      end
      rta_pkg::CMD_M_EV: begin
        if (flags.merge_hit) begin
          if (rd.start < ms) ms <= rd.start;
          if (rd.stop > me) me <= rd.stop;
          k <= k + CW'(1);
        end
      end
      rta_pkg::CMD_M_END: begin
        if (flags.k_eq_i) begin
          if (flags.full) status <= rta_pkg::ST_FULL;
          m <= n;
        end else begin
          m <= k;
          d <= i + CW'(1);
        end
      end
      rta_pkg::CMD_SU_WR: begin
        m <= m - CW'(1);
      end
      rta_pkg::CMD_SD_WR: begin
        m <= m + CW'(1);
        d <= d + CW'(1);
      end
      rta_pkg::CMD_G_URD: begin
        if (!flags.ui_lt_un) status <= rta_pkg::ST_NOFIT;
      end
      rta_pkg::CMD_G_UEV: begin
        if (flags.u_before) begin
          ui <= ui + CW'(1);
        end else if (flags.u_after) begin
          status <= rta_pkg::ST_NOFIT;
        end else begin
          hi <= (u_rd.stop < to) ? u_rd.stop : to;
          addr <= lo;
          ui <= ui + CW'(1);
        end
      end
      rta_pkg::CMD_G_TOP: begin
        aligned <= (addr + mask) & ~mask;
      end
      rta_pkg::CMD_G_FIT: begin
        addr <= aligned;
      end
      rta_pkg::CMD_G_RRD, rta_pkg::CMD_G_REV: begin
        if ((cmd.code == rta_pkg::CMD_G_RRD && !flags.j_lt_rn) ||
            (cmd.code == rta_pkg::CMD_G_REV && !flags.r_below && flags.r_clear)) begin
          where <= addr;
          a <= addr;
          e <= addr + size;
          tsel <= 1'b1;
          i <= '0;
          status <= rta_pkg::ST_OK;
        end else if (cmd.code == rta_pkg::CMD_G_REV) begin
          if (flags.r_below) j <= j + CW'(1);
          else addr <= r_rd.stop;
        end
      end
      rta_pkg::CMD_DONE: begin
        rsp.status <= status;
        rsp.result_addr <= (cur.op == rta_pkg::OP_ALLOC && status == rta_pkg::ST_OK) ?
                           where : lo_hi_unused;
      end
      default: begin
        status <= status;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_u <= CW'(SLOTS)) && (cnt_r <= CW'(SLOTS)))
    else $error("table count past capacity");
  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    wen |-> (wptr < CW'(SLOTS)))
    else $error("table write past capacity");
  a_merge_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.code == rta_pkg::CMD_M_END && !flags.k_eq_i) |-> (ms < me))
    else $error("merged range empty");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    (cmd.code == rta_pkg::CMD_DONE) |=> (rsp.status != 2'd3))
    else $error("bad response status");
`endif

endmodule

/* design/rta_ctrl.sv */
// Controller: sequences insert, merge, shift and gap search steps and
// owns the handshake state. Uses rta_pkg.
`timescale 1ns / 1ps
module rta_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  rta_pkg::flags_t flags,
  output rta_pkg::cmd_t   cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd2;
  localparam logic [4:0] S_I_RD     = 5'd3;
  localparam logic [4:0] S_I_EV     = 5'd4;
  localparam logic [4:0] S_M_RD     = 5'd5;
  localparam logic [4:0] S_M_EV     = 5'd6;
  localparam logic [4:0] S_M_END    = 5'd7;
  localparam logic [4:0] S_SU_RD    = 5'd8;
  localparam logic [4:0] S_SU_WR    = 5'd9;
  localparam logic [4:0] S_SD_RD    = 5'd10;
  localparam logic [4:0] S_SD_WR    = 5'd11;
  localparam logic [4:0] S_G_URD    = 5'd12;
  localparam logic [4:0] S_G_UEV    = 5'd13;
  localparam logic [4:0] S_G_TOP    = 5'd14;
  localparam logic [4:0] S_G_FIT    = 5'd15;
  localparam logic [4:0] S_G_RRD    = 5'd16;
  localparam logic [4:0] S_G_REV    = 5'd17;
  localparam logic [4:0] S_DONE     = 5'd18;

  logic [4:0] state, state_next;
  logic [4:0] found_next;
  logic done_fire;

  assign req_ready = state == S_IDLE;
  assign done_fire = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign found_next = (flags.op == rta_pkg::OP_QUERY) ? S_DONE : S_I_RD;

  always_comb begin
    state_next = state;
    cmd.code = rta_pkg::CMD_NOP;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.code = rta_pkg::CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.code = rta_pkg::CMD_DISPATCH;
        if (flags.op == rta_pkg::OP_ADD || flags.op == rta_pkg::OP_RESERVE) begin
          state_next = flags.ins_zero ? S_DONE : S_I_RD;
        end else begin
          state_next = flags.gap_bad ? S_DONE : S_G_URD;
        end
      end
      S_I_RD: begin
        cmd.code = rta_pkg::CMD_I_RD;
        state_next = flags.i_lt_n ? S_I_EV : S_M_RD;
      end
      S_I_EV: begin
        cmd.code = rta_pkg::CMD_I_EV;
        state_next = flags.ins_below ? S_I_RD : S_M_RD;
      end
      S_M_RD: begin
        cmd.code = rta_pkg::CMD_M_RD;
        state_next = flags.k_lt_n ? S_M_EV : S_M_END;
      end
      S_M_EV: begin
        cmd.code = rta_pkg::CMD_M_EV;
        state_next = flags.merge_hit ? S_M_RD : S_M_END;
      end
      S_M_END: begin
        cmd.code = rta_pkg::CMD_M_END;
        if (flags.k_eq_i) state_next = flags.full ? S_DONE : S_SU_RD;
        else state_next = S_SD_RD;
      end
      S_SU_RD: begin
        cmd.code = rta_pkg::CMD_SU_RD;
        state_next = flags.m_gt_i ? S_SU_WR : S_DONE;
      end
      S_SU_WR: begin
        cmd.code = rta_pkg::CMD_SU_WR;
        state_next = S_SU_RD;
      end
      S_SD_RD: begin
        cmd.code = rta_pkg::CMD_SD_RD;
        state_next = flags.m_lt_n ? S_SD_WR : S_DONE;
      end
      S_SD_WR: begin
        cmd.code = rta_pkg::CMD_SD_WR;
        state_next = S_SD_RD;
      end
      S_G_URD: begin
        cmd.code = rta_pkg::CMD_G_URD;
        state_next = flags.ui_lt_un ? S_G_UEV : S_DONE;
      end
      S_G_UEV: begin
        cmd.code = rta_pkg::CMD_G_UEV;
        if (flags.u_before) state_next = S_G_URD;
        else if (flags.u_after) state_next = S_DONE;
        else state_next = S_G_TOP;
      end
      S_G_TOP: begin
        cmd.code = rta_pkg::CMD_G_TOP;
        state_next = flags.top_stop ? S_G_URD : S_G_FIT;
      end
      S_G_FIT: begin
        cmd.code = rta_pkg::CMD_G_FIT;
        state_next = flags.fit_fail ? S_G_URD : S_G_RRD;
      end
      S_G_RRD: begin
        cmd.code = rta_pkg::CMD_G_RRD;
        state_next = flags.j_lt_rn ? S_G_REV : found_next;
      end
      S_G_REV: begin
        cmd.code = rta_pkg::CMD_G_REV;
        if (flags.r_below) state_next = S_G_RRD;
        else if (flags.r_clear) state_next = found_next;
        else state_next = S_G_TOP;
      end
      S_DONE: begin
        if (done_fire) begin
          cmd.code = rta_pkg::CMD_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done_fire) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

/* tb/sv/tb_region_table_allocator_top.sv */
// Testbench for region_table_allocator_top: directed rows, then random requests
// checked against a predictor of the usable and reserved tables.
// Depends on rta_pkg and the region_table_allocator_top RTL.
`timescale 1ns / 1ps
module tb_region_table_allocator_top;

  localparam int USABLE = 0;
  localparam int RESV = 1;
  localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int N_ITEMS = 1750;
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct {
    rta_pkg::req_t r;
    bit            typed;
    rta_pkg::rsp_t want;
  } row_t;

  logic           clk = 0;
  logic           rst = 1;
  logic           req_valid = 0;
  logic           rsp_ready = 0;
  rta_pkg::req_t  req = '0;
  logic           req_ready;
  logic           rsp_valid;
  rta_pkg::rsp_t  rsp;

  logic [63:0]   rg_start[2][rta_pkg::REGION_SLOTS];
  logic [63:0]   rg_len[2][rta_pkg::REGION_SLOTS];
  int            rg_count[2];
  rta_pkg::rsp_t pending_rsp[$];
  int            errors = 0;
  int            sent = 0;
  int            got = 0;
  int            n_full = 0;
  int            n_nofit = 0;
  longint        cycles = 0;
  bit            calm = 0;

  region_table_allocator_top uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [1:0] region_insert(int t, logic [63:0] a, logic [63:0] len);
    int n, i, k, m;
    logic [63:0] e, ms, me, re;
    n = rg_count[t];
    i = 0;
    if (len > TOP - a) len = TOP - a;
    if (len == 0) return rta_pkg::ST_OK;
    e = a + len;
    while (i < n && rg_start[t][i] + rg_len[t][i] < a) i++;
    k = i;
    ms = a;
    me = e;
    while (k < n && rg_start[t][k] <= me) begin
      re = rg_start[t][k] + rg_len[t][k];
      if (rg_start[t][k] < ms) ms = rg_start[t][k];
      if (re > me) me = re;
      k++;
    end
    if (k == i) begin
      if (n >= rta_pkg::REGION_SLOTS) return rta_pkg::ST_FULL;
      for (m = n; m > i; m--) begin
        rg_start[t][m] = rg_start[t][m-1];
        rg_len[t][m] = rg_len[t][m-1];
      end
      rg_start[t][i] = a;
      rg_len[t][i] = len;
      rg_count[t] = n + 1;
      return rta_pkg::ST_OK;
    end
    rg_start[t][i] = ms;
    rg_len[t][i] = me - ms;
    for (m = 0; k + m < n; m++) begin
      rg_start[t][i+1+m] = rg_start[t][k+m];
      rg_len[t][i+1+m] = rg_len[t][k+m];
    end
    rg_count[t] = n - (k - i - 1);
    return rta_pkg::ST_OK;
  endfunction

  function automatic bit gap_search(logic [63:0] size, logic [5:0] lg, logic [63:0] from,
                                    logic [63:0] to, output logic [63:0] where);
    logic [63:0] mask, s, e, lo, hi, addr;
    int j;
    mask = (64'd1 << lg) - 1;
    j = 0;
    where = 0;
    if (size == 0 || to <= from) return 0;
    for (int i = 0; i < rg_count[USABLE]; i++) begin
      s = rg_start[USABLE][i];
      e = s + rg_len[USABLE][i];
      if (e <= from) continue;
      if (s >= to) break;
      lo = (s > from) ? s : from;
      hi = (e < to) ? e : to;
      addr = lo;
      while (addr < hi) begin
        if (addr > TOP - mask) break;
        addr = (addr + mask) & ~mask;
        if (addr > hi || hi - addr < size) break;
        while (j < rg_count[RESV] && rg_start[RESV][j] + rg_len[RESV][j] <= addr) j++;
        if (j == rg_count[RESV] || rg_start[RESV][j] >= addr + size) begin
          where = addr;
          return 1;
        end
        addr = rg_start[RESV][j] + rg_len[RESV][j];
      end
    end
    return 0;
  endfunction

  function automatic rta_pkg::rsp_t allocator_step(rta_pkg::req_t r);
    rta_pkg::rsp_t o;
    logic [63:0] where;
    o = '0;
    case (r.op)
      rta_pkg::OP_ADD: o.status = region_insert(USABLE, r.base_addr, r.length);
      rta_pkg::OP_RESERVE: o.status = region_insert(RESV, r.base_addr, r.length);
      rta_pkg::OP_ALLOC: begin
        if (!gap_search(r.length, r.align_log2, r.base_addr, r.limit_addr, where))
          o.status = rta_pkg::ST_NOFIT;
        else if (region_insert(RESV, where, r.length) != rta_pkg::ST_OK)
          o.status = rta_pkg::ST_FULL;
        else
          o.result_addr = where;
      end
      default: begin
        if (r.length == 0 || r.length > TOP - r.base_addr ||
            !gap_search(r.length, 6'd0, r.base_addr, r.base_addr + r.length, where))
          o.status = rta_pkg::ST_NOFIT;
      end
    endcase
    return o;
  endfunction

  function automatic rta_pkg::req_t mk(logic [1:0] op, logic [63:0] b, logic [63:0] l,
                                       logic [63:0] lim, logic [5:0] al);
    rta_pkg::req_t r;
    r.op = op;
    r.base_addr = b;
    r.length = l;
    r.limit_addr = lim;
    r.align_log2 = al;
    return r;
  endfunction

  function automatic logic [63:0] rand_addr();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 64'($urandom_range(0, 'h3fff));
    if (pick < 80) return TOP - 64'($urandom_range(0, 'h3fff));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 0;
    if (pick < 85) return 64'($urandom_range(1, 'h400));
    return {$urandom, $urandom};
  endfunction

  function automatic rta_pkg::req_t rand_request();
    logic [63:0] b;
    b = rand_addr();
    return mk(2'($urandom_range(0, 3)), b, rand_len(),
              ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : b + rand_len() * 4,
              ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) :
                                            6'($urandom_range(0, 6)));
  endfunction

  // Send one request, push its expectation when accepted.
  task automatic issue(rta_pkg::req_t r, bit typed, rta_pkg::rsp_t want);
    rta_pkg::rsp_t exp_rsp;
    while (!calm && $urandom_range(0, 99) < 30) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    exp_rsp = allocator_step(r);
    pending_rsp.push_back(typed ? want : exp_rsp);
    sent++;
  endtask

  always @(posedge clk) begin
    rta_pkg::rsp_t w;
    if (rsp_valid && rsp_ready) begin
      got++;
      if (pending_rsp.size() == 0) begin
        $error("response with nothing pending: status %0d addr %h", rsp.status,
               rsp.result_addr);
        errors++;
      end else begin
        w = pending_rsp.pop_front();
        if (rsp.status !== w.status) begin
          $error("status: expected %0d actual %0d", w.status, rsp.status);
          errors++;
        end
        if (rsp.result_addr !== w.result_addr) begin
          $error("result_addr: expected %h actual %h", w.result_addr, rsp.result_addr);
          errors++;
        end
        if (rsp.status == rta_pkg::ST_FULL) n_full++;
        if (rsp.status == rta_pkg::ST_NOFIT) n_nofit++;
      end
    end
    rsp_ready <= calm || ($urandom_range(0, 99) >= 30);
  end

  initial begin
    row_t rows[$];
    rta_pkg::rsp_t nofit, ok, none;
    logic [63:0] b;
    int burst_t;
    nofit = '{status: rta_pkg::ST_NOFIT, result_addr: 64'd0};
    ok = '{status: rta_pkg::ST_OK, result_addr: 64'd0};
    none = '0;
    rows = '{
      '{mk(rta_pkg::OP_QUERY, 0, 16, 0, 0), 1, nofit},
      '{mk(rta_pkg::OP_ALLOC, 0, 16, TOP, 0), 1, nofit},
      '{mk(rta_pkg::OP_ADD, 'h5000, 0, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_ADD, 'h1000, 'h1000, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_ADD, 'h3000, 'h1000, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_ADD, 'h2000, 'h1000, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_QUERY, 'h1000, 'h3000, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_RESERVE, 'h1800, 'h100, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_QUERY, 'h1000, 'h3000, 0, 0), 1, nofit},
      '{mk(rta_pkg::OP_ALLOC, 0, 'h100, TOP, 8), 0, none},
      '{mk(rta_pkg::OP_ALLOC, 0, 0, TOP, 0), 1, nofit},
      '{mk(rta_pkg::OP_ALLOC, 'h4000, 'h10, 'h1000, 0), 1, nofit},
      '{mk(rta_pkg::OP_ALLOC, 'h2000, 'h10, 'h2000, 0), 1, nofit},
      '{mk(rta_pkg::OP_ADD, TOP - 'hfff, TOP, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_QUERY, TOP - 'h10, 'h20, 0, 0), 1, nofit},
      '{mk(rta_pkg::OP_RESERVE, TOP, 5, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_ALLOC, 0, 'h10, TOP, 63), 0, none},
      '{mk(rta_pkg::OP_ADD, 0, TOP, 0, 0), 1, ok},
      '{mk(rta_pkg::OP_QUERY, 0, 1, 0, 0), 0, none},
      '{mk(rta_pkg::OP_ALLOC, 1, 1, TOP, 63), 0, none},
      '{mk(rta_pkg::OP_ALLOC, 0, TOP, TOP, 0), 0, none},
      '{mk(rta_pkg::OP_ALLOC, 'h10, 'h40, 'h8000, 5), 0, none},
      '{mk(rta_pkg::OP_QUERY, TOP - 'h10, 'h10, 0, 0), 0, none}
    };
    rg_count[USABLE] = 0;
    rg_count[RESV] = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    foreach (rows[i]) issue(rows[i].r, rows[i].typed, rows[i].want);
    while (sent < N_ITEMS) begin
      calm <= (sent >= 700 && sent < 950);
      if ($urandom_range(0, 99) < 4) begin
        // spaced ranges that fill one table up to and past its capacity
        b = {$urandom, 12'h0} + ($urandom_range(0, 1) ? 64'h0 : {$urandom, 32'h0});
        burst_t = $urandom_range(0, 1);
        for (int k = 0; k < rta_pkg::REGION_SLOTS + 4; k++)
          issue(mk(burst_t ? rta_pkg::OP_RESERVE : rta_pkg::OP_ADD, b + k * 64, 16, 0, 0),
                0, none);
        for (int k = 0; k < 8; k++)
          issue(mk(rta_pkg::OP_ALLOC, b, $urandom_range(1, 48), b + 'h4000,
                   6'($urandom_range(0, 4))), 0, none);
      end else begin
        issue(rand_request(), 0, none);
      end
    end
    req_valid <= 0;
    calm <= 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("%0d requests sent, %0d responses checked (%0d table full, %0d no fit)",
             sent, got, n_full, n_nofit);
    $display("final table use: %0d usable, %0d reserved", rg_count[USABLE], rg_count[RESV]);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
